// File: rtl/core/sdfr_pkg.sv
`default_nettype none

package sdfr_pkg;

   // segment store geometry
   localparam int SEG_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(SEG_DEPTH);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int COORD_W   = 16;
   localparam int SEG_W     = 4 * COORD_W;

   // command codes
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // register file
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_SIZE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STROKE_WIDTH = 4'd1;
   localparam logic [6:0]  ICON_SIZE_RST    = 7'd24;
   localparam logic [11:0] STROKE_WIDTH_RST = 12'd512;

   // arithmetic widths
   localparam int SCL_W  = 24;            // coordinate * icon size
   localparam int V_W    = 25;            // vector components
   localparam int P_W    = 2 * V_W;       // component products
   localparam int DOT_W  = P_W + 1;       // dot products
   localparam int REM_W  = DOT_W + 1;     // divider remainder
   localparam int Q_W    = 16;            // projection fraction bits
   localparam int T_W    = Q_W + 2;       // signed t, up to 1.0
   localparam int TP_W   = T_W + V_W;     // t * v
   localparam int RND_W  = TP_W - Q_W;    // rounded t * v
   localparam int D_W    = 28;            // offset from closest point
   localparam int D2_W   = 2 * D_W;       // squared distance
   localparam int ROOT_W = D2_W / 2;
   localparam int SR_W   = ROOT_W + 3;
   localparam int HW_W   = 21;
   localparam int CV_W   = ROOT_W + 2;
   localparam int PR_W   = 23;

   localparam int DIV_STEPS  = Q_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(SQRT_STEPS);

   localparam int HW_FLOOR  = 17203;
   localparam int HALF_PX   = 12288;
   localparam int ONE_PX    = 24576;
   localparam int RECIP3    = 21846;      // 65536/3 rounded up

   // datapath operation per cycle
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_INIT,
      OP_READ,
      OP_SCALE,
      OP_VEC,
      OP_MUL,
      OP_DOT,
      OP_DIV,
      OP_TMUL,
      OP_ROUND,
      OP_SQ,
      OP_MIN,
      OP_ROOT_INIT,
      OP_ROOT,
      OP_COV,
      OP_PROD,
      OP_ALPHA
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic                capture;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [ADDR_W-1:0]   rd_addr;
   } dp_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/segment_distance_field_rasterizer.sv
`default_nettype none

// Segment distance field rasterizer.
// Request channel: a word is taken when start is high and busy is low.
//   req_command add appends one segment to the store (dropped when full),
//   clear empties the store, pixel returns the stroke alpha of
//   (req_pixel_col, req_pixel_row). Add and clear give no response and keep
//   busy low, so one may follow every cycle.
// Response channel: rsp_alpha is valid for the single cycle rsp_strobe is
//   high; the receiver cannot stall it. busy drops in that same cycle.
// Pixel job: busy stays high until the response, so no new word is taken
//   while a pixel is in work. For each stored segment: one memory read,
//   scaling, dot products and a restoring divider for the projection, then
//   a running minimum; the final square root takes one result bit per cycle.
// CSR channel: csr_ready is always high; index 0 icon size, index 1 stroke
//   width, other indexes ignored. Write only while busy is low.
// Reset: store empty, icon size 24, stroke width 512; store contents are
//   not cleared and are read only below the fill count.
module segment_distance_field_rasterizer
   import sdfr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_command,
   input  wire logic signed [15:0]      req_start_x,
   input  wire logic signed [15:0]      req_start_y,
   input  wire logic signed [15:0]      req_end_x,
   input  wire logic signed [15:0]      req_end_y,
   input  wire logic [5:0]              req_pixel_col,
   input  wire logic [5:0]              req_pixel_row,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_alpha,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   dp_ctrl_type     ctrl;
   logic [6:0]      icon_size_ff;
   logic [11:0]     stroke_width_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         icon_size_ff    <= ICON_SIZE_RST;
         stroke_width_ff <= STROKE_WIDTH_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ICON_SIZE)    icon_size_ff    <= csr_data[6:0];
         if (csr_index == CSR_STROKE_WIDTH) stroke_width_ff <= csr_data[11:0];
      end
   end

   sdfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .ctrl        (ctrl)
   );

   sdfr_dp u_dp (
      .clock         (clock),
      .ctrl          (ctrl),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .icon_size     (icon_size_ff),
      .stroke_width  (stroke_width_ff),
      .rsp_alpha     (rsp_alpha)
   );

   // a response only closes a pixel job
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a pixel job");

   // single response word per job
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response held for more than one cycle");

   // a job ends only with its response
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("pixel job ended without a response");

endmodule

`default_nettype wire

// File: rtl/core/sdfr_ctrl.sv
`default_nettype none

module sdfr_ctrl
   import sdfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [1:0]   req_command,
   output logic              busy,
   output logic              rsp_strobe,
   output dp_ctrl_type       ctrl
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_READ,
      S_SCALE,
      S_VEC,
      S_MUL,
      S_DOT,
      S_DIV,
      S_TMUL,
      S_ROUND,
      S_SQ,
      S_MIN,
      S_ROOT_INIT,
      S_ROOT,
      S_COV,
      S_PROD,
      S_ALPHA
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [ADDR_W-1:0]     idx_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  wr_en_ff;
   logic [ADDR_W-1:0]     wr_addr_ff;
   logic                  strobe_ff;
   logic                  accept;
   logic                  last_seg;
   dp_op_type             op;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign last_seg = ({1'b0, idx_ff} == (count_ff - CNT_W'(1)));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         step_ff   <= '0;
         wr_en_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         wr_en_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_command)
                     CMD_ADD: begin
                        if (count_ff < CNT_W'(SEG_DEPTH)) begin
                           wr_en_ff   <= 1'b1;
                           wr_addr_ff <= count_ff[ADDR_W-1:0];
                           count_ff   <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_PIXEL: state_ff <= S_INIT;
                     CMD_CLEAR: count_ff <= '0;
                     default: ;
                  endcase
               end
            end
            S_INIT: begin
               idx_ff   <= '0;
               state_ff <= (count_ff == '0) ? S_ROOT_INIT : S_READ;
            end
            S_READ:  state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_VEC;
            S_VEC:   state_ff <= S_MUL;
            S_MUL:   state_ff <= S_DOT;
            S_DOT: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_STEPS - 1)) state_ff <= S_TMUL;
            end
            S_TMUL:  state_ff <= S_ROUND;
            S_ROUND: state_ff <= S_SQ;
            S_SQ:    state_ff <= S_MIN;
            S_MIN: begin
               if (last_seg) begin
                  state_ff <= S_ROOT_INIT;
               end else begin
                  idx_ff   <= idx_ff + ADDR_W'(1);
                  state_ff <= S_READ;
               end
            end
            S_ROOT_INIT: begin
               step_ff  <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_ff <= S_COV;
            end
            S_COV:  state_ff <= S_PROD;
            S_PROD: state_ff <= S_ALPHA;
            S_ALPHA: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath operation for the current state
   always_comb begin
      case (state_ff)
         S_INIT:      op = OP_INIT;
         S_READ:      op = OP_READ;
         S_SCALE:     op = OP_SCALE;
         S_VEC:       op = OP_VEC;
         S_MUL:       op = OP_MUL;
         S_DOT:       op = OP_DOT;
         S_DIV:       op = OP_DIV;
         S_TMUL:      op = OP_TMUL;
         S_ROUND:     op = OP_ROUND;
         S_SQ:        op = OP_SQ;
         S_MIN:       op = OP_MIN;
         S_ROOT_INIT: op = OP_ROOT_INIT;
         S_ROOT:      op = OP_ROOT;
         S_COV:       op = OP_COV;
         S_PROD:      op = OP_PROD;
         S_ALPHA:     op = OP_ALPHA;
         default:     op = OP_IDLE;
      endcase
   end

   always_comb begin
      ctrl.op      = op;
      ctrl.capture = accept;
      ctrl.wr_en   = wr_en_ff;
      ctrl.wr_addr = wr_addr_ff;
      ctrl.rd_addr = idx_ff;
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// File: rtl/core/sdfr_dp.sv
`default_nettype none

module sdfr_dp
   import sdfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire dp_ctrl_type           ctrl,
   input  wire logic signed [15:0]    req_start_x,
   input  wire logic signed [15:0]    req_start_y,
   input  wire logic signed [15:0]    req_end_x,
   input  wire logic signed [15:0]    req_end_y,
   input  wire logic [5:0]            req_pixel_col,
   input  wire logic [5:0]            req_pixel_row,
   input  wire logic [6:0]            icon_size,
   input  wire logic [11:0]           stroke_width,
   output logic [7:0]                 rsp_alpha
);

   function automatic logic signed [SCL_W-1:0] scale(input logic signed [15:0] c,
                                                      input logic [6:0] s);
      logic signed [7:0] ss;
      ss = $signed({1'b0, s});
      return SCL_W'(c) * SCL_W'(ss);
   endfunction

   function automatic logic signed [D_W-1:0] round_off(input logic signed [TP_W-1:0] p);
      logic [TP_W-1:0]  m;
      logic [TP_W-1:0]  r;
      logic signed [D_W-1:0] rs;
      m  = p[TP_W-1] ? TP_W'(-p) : TP_W'(p);
      r  = (m + TP_W'(32768)) >> Q_W;
      rs = $signed(D_W'(r[RND_W-1:0]));
      return p[TP_W-1] ? -rs : rs;
   endfunction

   logic [SEG_W-1:0]          store_mem [SEG_DEPTH];
   logic [SEG_W-1:0]          seg_word_ff;
   logic [SEG_W-1:0]          rd_word_ff;
   logic [5:0]                col_ff, row_ff;

   logic signed [SCL_W-1:0]   x0_ff, y0_ff, x1_ff, y1_ff;
   logic [20:0]               px_ff, py_ff;
   logic signed [V_W-1:0]     vx_ff, vy_ff, wx_ff, wy_ff;
   logic signed [P_W-1:0]     vxx_ff, vyy_ff, wxvx_ff, wyvy_ff;
   logic [DOT_W-1:0]          vv_ff;
   logic                      deg_ff, full_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [Q_W-1:0]            q_ff;
   logic signed [TP_W-1:0]    tpx_ff, tpy_ff;
   logic signed [D_W-1:0]     dx_ff, dy_ff;
   logic [D2_W-1:0]           dxx_ff, dyy_ff;
   logic [D2_W-1:0]           best_ff;
   logic [D2_W-1:0]           n_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [SR_W-1:0]           srem_ff;
   logic [HW_W-1:0]           hw_ff;
   logic signed [CV_W-1:0]    cov_ff;
   logic                      zero_ff, sat_ff;
   logic [PR_W-1:0]           prod_ff;
   logic [7:0]                alpha_ff;

   logic signed [DOT_W-1:0]   wv;
   logic [DOT_W-1:0]          vv;
   logic [REM_W-1:0]          rem_sh;
   logic signed [T_W-1:0]     t;
   logic [D2_W-1:0]           d2;
   logic [SR_W-1:0]           srem_sh;
   logic [SR_W-1:0]           trial;
   logic [HW_W-1:0]           hw_raw;
   logic [9:0]                quot_in;
   logic [24:0]               quot_prod;

   assign vv      = DOT_W'(vxx_ff) + DOT_W'(vyy_ff);
   assign wv      = DOT_W'(wxvx_ff) + DOT_W'(wyvy_ff);
   assign rem_sh  = {rem_ff[REM_W-2:0], 1'b0};
   assign t       = deg_ff  ? '0 :
                    full_ff ? T_W'(1 << Q_W) : $signed(T_W'(q_ff));
   assign d2      = dxx_ff + dyy_ff;
   assign srem_sh = {srem_ff[SR_W-3:0], n_ff[D2_W-1 -: 2]};
   assign trial   = SR_W'({root_ff, 2'b01});
   assign hw_raw  = HW_W'({19'(stroke_width) * 19'(icon_size), 1'b0});
   assign quot_in = prod_ff[PR_W-1 -: 10];
   assign quot_prod = 25'(quot_in) * 25'(RECIP3);

   // segment store
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) store_mem[ctrl.wr_addr] <= seg_word_ff;
      if (ctrl.op == OP_READ) rd_word_ff <= store_mem[ctrl.rd_addr];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         seg_word_ff <= {req_end_y, req_end_x, req_start_y, req_start_x};
         col_ff      <= req_pixel_col;
         row_ff      <= req_pixel_row;
      end
   end

   // distance datapath
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_INIT: best_ff <= '1;
         OP_SCALE: begin
            x0_ff <= scale(rd_word_ff[15:0],  icon_size);
            y0_ff <= scale(rd_word_ff[31:16], icon_size);
            x1_ff <= scale(rd_word_ff[47:32], icon_size);
            y1_ff <= scale(rd_word_ff[63:48], icon_size);
            // pixel center: (2*col+1)*3*4096
            px_ff <= {9'({col_ff, 1'b1}) * 9'd3, 12'd0};
            py_ff <= {9'({row_ff, 1'b1}) * 9'd3, 12'd0};
         end
         OP_VEC: begin
            vx_ff <= V_W'(x1_ff) - V_W'(x0_ff);
            vy_ff <= V_W'(y1_ff) - V_W'(y0_ff);
            wx_ff <= $signed(V_W'(px_ff)) - V_W'(x0_ff);
            wy_ff <= $signed(V_W'(py_ff)) - V_W'(y0_ff);
         end
         OP_MUL: begin
            vxx_ff  <= P_W'(vx_ff) * P_W'(vx_ff);
            vyy_ff  <= P_W'(vy_ff) * P_W'(vy_ff);
            wxvx_ff <= P_W'(wx_ff) * P_W'(vx_ff);
            wyvy_ff <= P_W'(wy_ff) * P_W'(vy_ff);
         end
         OP_DOT: begin
            vv_ff   <= vv;
            deg_ff  <= (vv == '0) || (wv <= 0);
            full_ff <= ($signed({1'b0, vv}) <= (DOT_W+1)'(wv));
            rem_ff  <= REM_W'($unsigned(wv));
            q_ff    <= '0;
         end
         OP_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_sh >= REM_W'(vv_ff)) begin
               rem_ff <= rem_sh - REM_W'(vv_ff);
               q_ff   <= {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               q_ff   <= {q_ff[Q_W-2:0], 1'b0};
            end
         end
         OP_TMUL: begin
            tpx_ff <= TP_W'(t) * TP_W'(vx_ff);
            tpy_ff <= TP_W'(t) * TP_W'(vy_ff);
         end
         OP_ROUND: begin
            dx_ff <= D_W'(wx_ff) - round_off(tpx_ff);
            dy_ff <= D_W'(wy_ff) - round_off(tpy_ff);
         end
         OP_SQ: begin
            dxx_ff <= D2_W'(D2_W'(dx_ff) * D2_W'(dx_ff));
            dyy_ff <= D2_W'(D2_W'(dy_ff) * D2_W'(dy_ff));
         end
         OP_MIN: begin
            if (d2 < best_ff) best_ff <= d2;
         end
         OP_ROOT_INIT: begin
            n_ff    <= best_ff;
            root_ff <= '0;
            srem_ff <= '0;
            hw_ff   <= (hw_raw < HW_W'(HW_FLOOR)) ? HW_W'(HW_FLOOR) : hw_raw;
         end
         OP_ROOT: begin
            // one root bit per cycle
            n_ff <= {n_ff[D2_W-3:0], 2'b00};
            if (srem_sh >= trial) begin
               srem_ff <= srem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_COV: begin
            cov_ff <= CV_W'(HALF_PX) + $signed(CV_W'(hw_ff)) - $signed(CV_W'(root_ff));
         end
         OP_ALPHA: ;
         default: ;
      endcase
   end

   // coverage to alpha; divide by 24576 as shift by 13 and multiply by 1/3
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_ALPHA) begin
         alpha_ff <= zero_ff ? 8'd0 : sat_ff ? 8'd255 : quot_prod[23:16];
      end
   end

   // saturation and scaled coverage, in the cycle after the coverage
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_PROD) begin
         zero_ff <= (cov_ff <= 0);
         sat_ff  <= (cov_ff >= CV_W'(ONE_PX));
         prod_ff <= PR_W'({cov_ff, 8'd0}) - PR_W'(cov_ff) + PR_W'(HALF_PX);
      end
   end

   assign rsp_alpha = alpha_ff;

endmodule

`default_nettype wire

// File: bench/segment_distance_field_rasterizer_tb.sv
`timescale 1ns / 1ps

module segment_distance_field_rasterizer_tb;
   import sdfr_pkg::*;

   localparam logic [1:0]           CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd9;
   localparam int                   ITEM_TARGET  = 1100;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_command;
   logic signed [15:0]    req_start_x, req_start_y, req_end_x, req_end_y;
   logic [5:0]            req_pixel_col, req_pixel_row;
   logic                  rsp_strobe;
   logic [7:0]            rsp_alpha;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   segment_distance_field_rasterizer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_pixel_col(req_pixel_col), .req_pixel_row(req_pixel_row),
      .rsp_strobe(rsp_strobe), .rsp_alpha(rsp_alpha),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow of the block state
   logic signed [15:0] seg_x0 [SEG_DEPTH];
   logic signed [15:0] seg_y0 [SEG_DEPTH];
   logic signed [15:0] seg_x1 [SEG_DEPTH];
   logic signed [15:0] seg_y1 [SEG_DEPTH];
   int                 seg_fill;
   logic [6:0]         icon_px;
   logic [11:0]        stroke_units;

   logic [7:0] alpha_queue [$];
   int         errors;
   int         items;
   bit         quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // round t*v / 2^16 half away from zero
   function automatic longint round_q16(longint p);
      longint m;
      m = (p < 0) ? -p : p;
      m = (m + 32768) >>> 16;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // stroke coverage of one pixel over the shadow store
   function automatic logic [7:0] stroke_alpha(logic [5:0] col, logic [5:0] row);
      longint s, px, py, x0, y0, vx, vy, wx, wy, vv, wv, t, dx, dy, d, hw, cov;
      longint unsigned best, d2;
      s = icon_px;
      px = (2 * longint'(col) + 1) * HALF_PX;
      py = (2 * longint'(row) + 1) * HALF_PX;
      if (seg_fill == 0) return 8'd0;
      best = '1;
      for (int i = 0; i < seg_fill; i++) begin
         x0 = longint'(seg_x0[i]) * s;
         y0 = longint'(seg_y0[i]) * s;
         vx = longint'(seg_x1[i]) * s - x0;
         vy = longint'(seg_y1[i]) * s - y0;
         wx = px - x0;
         wy = py - y0;
         vv = vx * vx + vy * vy;
         wv = wx * vx + wy * vy;
         if (vv == 0 || wv <= 0) t = 0;
         else if (wv >= vv) t = 65536;
         else t = longint'(($unsigned(wv) << 16) / $unsigned(vv));
         dx = wx - round_q16(t * vx);
         dy = wy - round_q16(t * vy);
         d2 = $unsigned(dx * dx) + $unsigned(dy * dy);
         if (d2 < best) best = d2;
      end
      d = longint'(int_sqrt(best));
      hw = longint'(stroke_units) * s * 2;
      if (hw < HW_FLOOR) hw = HW_FLOOR;
      cov = HALF_PX + hw - d;
      if (cov <= 0) return 8'd0;
      if (cov >= ONE_PX) return 8'd255;
      return 8'((cov * 255 + HALF_PX) / ONE_PX);
   endfunction

   // one request word, held until taken; start stays high on return
   task automatic send_word(logic [1:0] cmd, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] ex, logic signed [15:0] ey,
                            logic [5:0] col, logic [5:0] row);
      start         <= 1'b1;
      req_command   <= cmd;
      req_start_x   <= sx;
      req_start_y   <= sy;
      req_end_x     <= ex;
      req_end_y     <= ey;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (busy);
      items++;
      case (cmd)
         CMD_ADD: if (seg_fill < SEG_DEPTH) begin
            seg_x0[seg_fill] = sx;
            seg_y0[seg_fill] = sy;
            seg_x1[seg_fill] = ex;
            seg_y1[seg_fill] = ey;
            seg_fill++;
         end
         CMD_PIXEL: alpha_queue.push_back(stroke_alpha(col, row));
         CMD_CLEAR: seg_fill = 0;
         default: ;
      endcase
   endtask

   task automatic add_seg(logic signed [15:0] sx, logic signed [15:0] sy,
                          logic signed [15:0] ex, logic signed [15:0] ey);
      send_word(CMD_ADD, sx, sy, ex, ey, 6'd0, 6'd0);
   endtask

   task automatic ask_pixel(logic [5:0] col, logic [5:0] row);
      send_word(CMD_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                col, row);
   endtask

   // random sender gap with start low, skipped while quiet
   task automatic maybe_pause();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (alpha_queue.size() != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // register write, block idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ICON_SIZE) icon_px = val[6:0];
      else if (idx == CSR_STROKE_WIDTH) stroke_units = val;
      @(posedge clock);
   endtask

   task automatic set_config(logic [6:0] sz, logic [11:0] sw);
      drain();
      write_reg(CSR_ICON_SIZE, {5'd0, sz});
      write_reg(CSR_STROKE_WIDTH, sw);
   endtask

   // result checker; the receiver never stalls
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (alpha_queue.size() == 0) begin
            $error("unexpected alpha word %0d", rsp_alpha);
            errors++;
         end else begin
            logic [7:0] want;
            want = alpha_queue.pop_front();
            if (rsp_alpha !== want) begin
               $error("alpha: expected %0d, got %0d", want, rsp_alpha);
               errors++;
            end
         end
      end
   end

   // reset defaults, empty store, edges of coordinates and pixels, a point segment, an unused command and clear
   task automatic test_directed();
      ask_pixel(6'd0, 6'd0);
      ask_pixel(6'd63, 6'd63);
      add_seg(16'sd2048, 16'sd2048, 16'sd22528, 16'sd22528);
      add_seg(16'sd12288, 16'sd12288, 16'sd12288, 16'sd12288);   // point
      ask_pixel(6'd1, 6'd1);
      ask_pixel(6'd12, 6'd12);
      ask_pixel(6'd5, 6'd20);
      ask_pixel(6'd63, 6'd0);   // outside the icon
      add_seg(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      add_seg(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      ask_pixel(6'd0, 6'd63);
      ask_pixel(6'd40, 6'd2);
      send_word(CMD_UNUSED, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd3, 6'd3);
      ask_pixel(6'd3, 6'd3);
      send_word(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
      ask_pixel(6'd12, 6'd12);
   endtask

   // register extremes, unmapped index, zero icon size
   task automatic test_registers();
      drain();
      write_reg(CSR_UNMAPPED, 12'hFFF);
      add_seg(16'sd0, 16'sd0, 16'sd24576, 16'sd24576);
      ask_pixel(6'd10, 6'd10);
      set_config(7'd0, 12'd0);
      ask_pixel(6'd0, 6'd0);
      ask_pixel(6'd63, 6'd63);
      set_config(7'd127, 12'd4095);
      ask_pixel(6'd20, 6'd20);
      ask_pixel(6'd63, 6'd0);
      set_config(7'd1, 12'd0);
      ask_pixel(6'd0, 6'd0);
      set_config(7'd64, 12'd4095);
      ask_pixel(6'd33, 6'd31);
      set_config(7'd24, 12'd512);
   endtask

   // fill the store past its depth; extra adds are dropped
   task automatic test_store_full();
      send_word(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
      for (int i = 0; i < SEG_DEPTH + 3; i++) begin
         add_seg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         maybe_pause();
      end
      add_seg(16'sd12288, 16'sd12288, 16'sd12288, 16'sd12288);
      ask_pixel(6'd12, 6'd12);
      send_word(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
   endtask

   function automatic logic signed [15:0] rand_coord(bit wide);
      if (wide) return 16'($urandom);
      return 16'($urandom_range(0, 24576 + 4096)) - 16'sd2048;
   endfunction

   // small drawings with random content under varying settings
   task automatic test_random();
      int nseg;
      int npix;
      while (items < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0)
            set_config(7'($urandom_range(1, 64)), 12'($urandom_range(0, 4095)));
         quiet = (items > ITEM_TARGET - 150);
         send_word(CMD_CLEAR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 6'd0);
         maybe_pause();
         nseg = $urandom_range(0, 12);
         for (int i = 0; i < nseg; i++) begin
            bit wide;
            wide = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
               logic signed [15:0] cx, cy;
               cx = rand_coord(wide);
               cy = rand_coord(wide);
               add_seg(cx, cy, cx, cy);
            end else begin
               add_seg(rand_coord(wide), rand_coord(wide), rand_coord(wide), rand_coord(wide));
            end
            maybe_pause();
         end
         npix = $urandom_range(1, 8);
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 15) == 0)
               send_word(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 6'($urandom), 6'($urandom));
            else if ($urandom_range(0, 7) == 0)
               ask_pixel(6'($urandom), 6'($urandom));
            else
               ask_pixel(6'($urandom_range(0, icon_px > 0 ? icon_px - 1 : 0)),
                         6'($urandom_range(0, icon_px > 0 ? icon_px - 1 : 0)));
            maybe_pause();
         end
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_command   = CMD_ADD;
      req_start_x   = '0;
      req_start_y   = '0;
      req_end_x     = '0;
      req_end_y     = '0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_ICON_SIZE;
      csr_data      = '0;
      seg_fill      = 0;
      icon_px       = ICON_SIZE_RST;
      stroke_units  = STROKE_WIDTH_RST;
      errors        = 0;
      items         = 0;
      quiet         = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_registers();
      test_store_full();
      test_random();

      if (errors == 0) $display("segment_distance_field_rasterizer_tb: clean");
      else $display("segment_distance_field_rasterizer_tb: errors");
      $finish;
   end

   // watchdog
   initial begin
      #60_000_000;
      $display("segment_distance_field_rasterizer_tb: errors");
      $finish;
   end

endmodule
